// ----- design/assert_macros.svh -----
// Assertion macros shared by the RTL.
// No dependencies; take in by include inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Implication with the consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ----- design/bdlp_pkg.sv -----
// Types, constants and helpers of the button debounce / long-press block.
// No dependencies.
`default_nettype none

package bdlp_pkg;

    localparam int unsigned TICKS_W   = 16;
    localparam int unsigned EVNUM_W   = 8;
    localparam int unsigned CFG_IDX_W = 1;

    typedef logic [TICKS_W-1:0] t_ticks;
    typedef logic [EVNUM_W-1:0] t_evnum;

    localparam t_ticks TICKS_RESET = '0;

    // Item kind
    typedef enum logic {
        CMD_CHANGE = 1'b0,
        CMD_TICK   = 1'b1
    } t_command;

    // Reported event
    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_PUSH    = 2'd1,
        EV_LONG    = 2'd2,
        EV_RELEASE = 2'd3
    } t_event_kind;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LONG_PRESS = 1'b0,
        CFG_DEBOUNCE   = 1'b1
    } t_cfg_reg;

    // Button state machine, one-hot
    typedef enum logic [4:0] {
        ST_IDLE      = 5'b00001,
        ST_PRESS_DEB = 5'b00010,
        ST_LONG_WAIT = 5'b00100,
        ST_REL_DEB   = 5'b01000,
        ST_WAIT_REL  = 5'b10000
    } t_state;

    // Status handed up from the state machine
    typedef struct packed {
        t_state state;
        logic   change_en;
    } t_fsm_status;

    // Event number: counts up, wraps from all-ones to 1, never 0
    function automatic t_evnum next_number(input t_evnum cur);
        t_evnum nxt;
        nxt = cur + t_evnum'(1);
        if (nxt == '0) begin
            nxt = t_evnum'(1);
        end
        return nxt;
    endfunction

endpackage

`default_nettype wire

// ----- design/bdlp_if.sv -----
// Valid/ready channel interfaces: input items, result items, register writes.
// Depends on bdlp_pkg.
`default_nettype none

interface bdlp_in_if import bdlp_pkg::*; ();
    logic valid;
    logic ready;
    logic command;
    logic button_pressed;

    modport source (output valid, output command, output button_pressed, input ready);
    modport sink   (input valid, input command, input button_pressed, output ready);
endinterface

interface bdlp_out_if import bdlp_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [1:0]  event_kind;
    t_evnum      event_number;

    modport source (output valid, output event_kind, output event_number, input ready);
    modport sink   (input valid, input event_kind, input event_number, output ready);
endinterface

interface bdlp_cfg_if import bdlp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    t_ticks               data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- design/bdlp_fsm.sv -----
// Button state machine: debounce and long-press counters, event counter,
// and the combinational next-state / event logic for one item.
// Depends on bdlp_pkg.
`default_nettype none

module bdlp_fsm import bdlp_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_step,
    input  wire logic        i_command,
    input  wire logic        i_button_pressed,
    input  wire t_ticks      i_long_press_ticks,
    input  wire t_ticks      i_debounce_ticks,
    output t_event_kind      o_event_kind,
    output t_evnum           o_event_number,
    output t_fsm_status      o_status
);

    t_state r_state,      n_state;
    logic   r_last_level, n_last_level;
    logic   r_change_en,  n_change_en;
    t_ticks r_deb_left,   n_deb_left;
    t_ticks r_long_left,  n_long_left;
    t_evnum r_ev_cnt,     n_ev_cnt;

    t_event_kind w_kind;
    t_evnum      w_num;

    // Next state and event for the item at the input register
    always_comb begin
        n_state      = r_state;
        n_last_level = r_last_level;
        n_change_en  = r_change_en;
        n_deb_left   = r_deb_left;
        n_long_left  = r_long_left;
        n_ev_cnt     = r_ev_cnt;
        w_kind       = EV_NONE;
        w_num        = '0;

        if (t_command'(i_command) == CMD_CHANGE) begin
            // pin change: ignored while masked or when the level did not move
            if (r_change_en && (i_button_pressed != r_last_level)) begin
                n_last_level = i_button_pressed;
                if (i_button_pressed) begin
                    if (r_state == ST_IDLE) begin
                        n_change_en = 1'b0;
                        n_long_left = i_long_press_ticks;
                        n_deb_left  = i_debounce_ticks;
                        n_state     = ST_PRESS_DEB;
                    end
                end else if (r_state == ST_LONG_WAIT) begin
                    w_kind      = EV_PUSH;
                    n_ev_cnt    = next_number(r_ev_cnt);
                    w_num       = n_ev_cnt;
                    n_change_en = 1'b0;
                    n_long_left = '0;
                    n_deb_left  = i_debounce_ticks;
                    n_state     = ST_REL_DEB;
                end else if (r_state == ST_WAIT_REL) begin
                    w_kind      = EV_RELEASE;
                    w_num       = r_ev_cnt;
                    n_change_en = 1'b0;
                    n_deb_left  = i_debounce_ticks;
                    n_state     = ST_REL_DEB;
                end
            end
        end else begin
            // tick: debounce counter first
            if (n_deb_left != '0) begin
                n_deb_left = n_deb_left - t_ticks'(1);
                if (n_deb_left == '0) begin
                    if (i_button_pressed) begin
                        if (n_state == ST_PRESS_DEB) begin
                            n_change_en = 1'b1;
                            n_state     = ST_LONG_WAIT;
                        end else if (n_state == ST_REL_DEB) begin
                            n_long_left = i_long_press_ticks;
                            n_change_en = 1'b1;
                            n_state     = ST_LONG_WAIT;
                        end
                    end else begin
                        if (n_state == ST_PRESS_DEB) begin
                            w_kind      = EV_PUSH;
                            n_ev_cnt    = next_number(n_ev_cnt);
                            w_num       = n_ev_cnt;
                            n_long_left = '0;
                            n_deb_left  = i_debounce_ticks;
                            n_state     = ST_REL_DEB;
                        end else if (n_state == ST_REL_DEB) begin
                            n_change_en = 1'b1;
                            n_state     = ST_IDLE;
                        end
                    end
                end
            end
            // then the long-press counter, on what debounce left
            if (n_long_left != '0) begin
                n_long_left = n_long_left - t_ticks'(1);
                if (n_long_left == '0) begin
                    if (i_button_pressed) begin
                        if (n_state == ST_PRESS_DEB) begin
                            w_kind      = EV_LONG;
                            n_ev_cnt    = next_number(n_ev_cnt);
                            w_num       = n_ev_cnt;
                            n_change_en = 1'b1;
                            n_deb_left  = '0;
                            n_state     = ST_WAIT_REL;
                        end else if (n_state == ST_LONG_WAIT) begin
                            w_kind   = EV_LONG;
                            n_ev_cnt = next_number(n_ev_cnt);
                            w_num    = n_ev_cnt;
                            n_state  = ST_WAIT_REL;
                        end
                    end else if (n_state == ST_LONG_WAIT) begin
                        w_kind      = EV_PUSH;
                        n_ev_cnt    = next_number(n_ev_cnt);
                        w_num       = n_ev_cnt;
                        n_change_en = 1'b0;
                        n_long_left = '0;
                        n_deb_left  = i_debounce_ticks;
                        n_state     = ST_REL_DEB;
                    end
                end
            end
        end
    end

    // State registers, updated once per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_last_level <= 1'b0;
            r_change_en  <= 1'b1;
            r_deb_left   <= '0;
            r_long_left  <= '0;
            r_ev_cnt     <= '0;
        end else if (i_step) begin
            r_state      <= n_state;
            r_last_level <= n_last_level;
            r_change_en  <= n_change_en;
            r_deb_left   <= n_deb_left;
            r_long_left  <= n_long_left;
            r_ev_cnt     <= n_ev_cnt;
        end
    end

    assign o_event_kind   = w_kind;
    assign o_event_number = w_num;
    assign o_status       = '{state: r_state, change_en: r_change_en};

endmodule

`default_nettype wire

// ----- design/button_debounce_long_press.sv -----
// Push-button qualifier: debounces a button from pin-change and timer-tick
// items and reports push, long-press and release-after-long-press events,
// each numbered 1..255 (wrapping past 0). Exactly one result word per input
// word; kind 0 means no event. A word is taken every clock while the result
// side keeps up: it lands in an input register, then the state machine updates
// and writes the result register together, so throughput is one word per
// cycle, set by the single state update per word. The result register frees
// the input side while a result waits. Registers: index 0 long-press ticks,
// index 1 debounce ticks, both reset to 0, always ready.
// Depends on bdlp_pkg, bdlp_if, bdlp_fsm and assert_macros.svh.
`default_nettype none

module button_debounce_long_press import bdlp_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    bdlp_in_if.sink     i_in,
    bdlp_cfg_if.sink    i_cfg,
    bdlp_out_if.source  o_out
);

    `include "assert_macros.svh"

    // Configuration registers
    t_ticks r_long_press_ticks;
    t_ticks r_debounce_ticks;

    // Input register
    logic r_in_valid;
    logic r_in_command;
    logic r_in_level;

    // Result register
    logic        r_out_valid;
    t_event_kind r_out_kind;
    t_evnum      r_out_number;

    logic        w_advance;
    logic        w_in_accept;
    t_event_kind w_kind;
    t_evnum      w_num;
    t_fsm_status w_status;

    assign i_cfg.ready = 1'b1;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_press_ticks <= TICKS_RESET;
            r_debounce_ticks   <= TICKS_RESET;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_reg'(i_cfg.index))
                CFG_LONG_PRESS: r_long_press_ticks <= i_cfg.data;
                CFG_DEBOUNCE:   r_debounce_ticks   <= i_cfg.data;
                default:        ;
            endcase
        end
    end

    // Pipeline handshake: move a word on when the result slot is free
    assign w_advance   = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || w_advance;
    assign w_in_accept = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_command <= i_in.command;
            r_in_level   <= i_in.button_pressed;
        end
    end

    // State machine
    bdlp_fsm u_fsm (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_step             (w_advance),
        .i_command          (r_in_command),
        .i_button_pressed   (r_in_level),
        .i_long_press_ticks (r_long_press_ticks),
        .i_debounce_ticks   (r_debounce_ticks),
        .o_event_kind       (w_kind),
        .o_event_number     (w_num),
        .o_status           (w_status)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_kind   <= w_kind;
            r_out_number <= w_num;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.event_kind   = r_out_kind;
    assign o_out.event_number = r_out_number;

    // Checks
    `ASSERT_IMPL(a_num_matches_kind, i_clk, i_rst_n, o_out.valid, ((r_out_kind == EV_NONE) == (r_out_number == '0)), "event number and kind disagree")
    `ASSERT_NEXT(a_in_word_kept, i_clk, i_rst_n, r_in_valid && !w_advance, r_in_valid, "input word dropped while stalled")
    `ASSERT_IMPL(a_mask_in_debounce, i_clk, i_rst_n, !w_status.change_en, ((w_status.state == ST_PRESS_DEB) || (w_status.state == ST_REL_DEB)), "change mask off outside a debounce state")

endmodule

`default_nettype wire

// ----- tb/sv/button_debounce_long_press_tb.sv -----
// Self-checking testbench for the button debounce / long-press qualifier.
// Depends on bdlp_pkg, bdlp_if and button_debounce_long_press; drives
// press/tick words, predicts every result word and checks it in order.
`default_nettype none

module button_debounce_long_press_tb import bdlp_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PRESSURE_HOLD  = 300;

    typedef struct packed {
        t_event_kind kind;
        t_evnum      num;
    } t_result_word;

    logic clk = 1'b0;
    logic rst_n;

    bdlp_in_if  in_ch ();
    bdlp_out_if out_ch ();
    bdlp_cfg_if cfg_ch ();

    button_debounce_long_press dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch.sink),
        .i_cfg   (cfg_ch.sink),
        .o_out   (out_ch.source)
    );

    // Clock, 10 ns period
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predicted button state and register copies
    t_ticks  cfg_long     = TICKS_RESET;
    t_ticks  cfg_deb      = TICKS_RESET;
    t_state  btn_state    = ST_IDLE;
    logic    last_level   = 1'b0;
    logic    change_en    = 1'b1;
    t_ticks  deb_left     = '0;
    t_ticks  long_left    = '0;
    t_evnum  ev_count     = '0;

    t_result_word expected_events[$];
    int  mismatches   = 0;
    int  words_sent   = 0;
    int  idle_cycles  = 0;
    bit  jitter_on    = 1'b1;
    bit  pressure_req = 1'b0;
    int  hold_left    = 0;

    // Event number advances and skips zero on wrap
    function automatic t_evnum bump_event_number();
        ev_count = ev_count + t_evnum'(1);
        if (ev_count == '0) begin
            ev_count = t_evnum'(1);
        end
        return ev_count;
    endfunction

    // One word through the button state machine
    function automatic t_result_word predict_button(input t_command cmd, input logic lvl);
        t_result_word res;
        res.kind = EV_NONE;
        res.num  = '0;
        if (cmd == CMD_CHANGE) begin
            if (change_en && lvl != last_level) begin
                last_level = lvl;
                if (lvl) begin
                    if (btn_state == ST_IDLE) begin
                        change_en = 1'b0;
                        long_left = cfg_long;
                        deb_left  = cfg_deb;
                        btn_state = ST_PRESS_DEB;
                    end
                end else if (btn_state == ST_LONG_WAIT) begin
                    res.kind  = EV_PUSH;
                    res.num   = bump_event_number();
                    change_en = 1'b0;
                    long_left = '0;
                    deb_left  = cfg_deb;
                    btn_state = ST_REL_DEB;
                end else if (btn_state == ST_WAIT_REL) begin
                    res.kind  = EV_RELEASE;
                    res.num   = ev_count;
                    change_en = 1'b0;
                    deb_left  = cfg_deb;
                    btn_state = ST_REL_DEB;
                end
            end
        end else begin
            // debounce counter first
            if (deb_left != '0) begin
                deb_left = deb_left - t_ticks'(1);
                if (deb_left == '0) begin
                    if (lvl) begin
                        if (btn_state == ST_PRESS_DEB) begin
                            change_en = 1'b1;
                            btn_state = ST_LONG_WAIT;
                        end else if (btn_state == ST_REL_DEB) begin
                            long_left = cfg_long;
                            change_en = 1'b1;
                            btn_state = ST_LONG_WAIT;
                        end
                    end else begin
                        if (btn_state == ST_PRESS_DEB) begin
                            res.kind  = EV_PUSH;
                            res.num   = bump_event_number();
                            long_left = '0;
                            deb_left  = cfg_deb;
                            btn_state = ST_REL_DEB;
                        end else if (btn_state == ST_REL_DEB) begin
                            change_en = 1'b1;
                            btn_state = ST_IDLE;
                        end
                    end
                end
            end
            // then the long-press counter, on what debounce left behind
            if (long_left != '0) begin
                long_left = long_left - t_ticks'(1);
                if (long_left == '0) begin
                    if (lvl) begin
                        if (btn_state == ST_PRESS_DEB) begin
                            res.kind  = EV_LONG;
                            res.num   = bump_event_number();
                            change_en = 1'b1;
                            deb_left  = '0;
                            btn_state = ST_WAIT_REL;
                        end else if (btn_state == ST_LONG_WAIT) begin
                            res.kind  = EV_LONG;
                            res.num   = bump_event_number();
                            btn_state = ST_WAIT_REL;
                        end
                    end else if (btn_state == ST_LONG_WAIT) begin
                        res.kind  = EV_PUSH;
                        res.num   = bump_event_number();
                        change_en = 1'b0;
                        long_left = '0;
                        deb_left  = cfg_deb;
                        btn_state = ST_REL_DEB;
                    end
                end
            end
        end
        return res;
    endfunction

    // Send one input word, with an optional gap before it
    task automatic send_word(input t_command cmd, input logic lvl);
        t_result_word res;
        int gap;
        @(negedge clk);
        if (jitter_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 14);
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.command        <= cmd;
        in_ch.button_pressed <= lvl;
        do @(posedge clk); while (!in_ch.ready);
        res = predict_button(cmd, lvl);
        expected_events.push_back(res);
        words_sent++;
    endtask

    task automatic send_ticks(input logic lvl, input int count);
        repeat (count) send_word(CMD_TICK, lvl);
    endtask

    // Stop sending and wait until every result word is back
    task automatic settle();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input t_ticks val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        if (idx == CFG_LONG_PRESS) begin
            cfg_long = val;
        end else begin
            cfg_deb = val;
        end
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Press with occasional bounce, then release and settle ticks
    task automatic random_press();
        int hold;
        int rel;
        int k;
        hold = $urandom_range(0, int'(cfg_long) + int'(cfg_deb) + 3);
        rel  = $urandom_range(0, int'(cfg_deb) + 3);
        send_word(CMD_CHANGE, 1'b1);
        for (k = 0; k < hold; k++) begin
            if ($urandom_range(0, 11) == 0) begin
                send_word(CMD_CHANGE, 1'b0);
                send_word(CMD_CHANGE, 1'b1);
            end
            send_word(CMD_TICK, $urandom_range(0, 9) != 0);
        end
        send_word(CMD_CHANGE, 1'b0);
        for (k = 0; k < rel; k++) begin
            send_word(CMD_TICK, $urandom_range(0, 9) == 0);
        end
    endtask

    task automatic random_noise();
        repeat ($urandom_range(1, 6)) begin
            send_word(t_command'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    // Push, short press, masked change and long press with release
    task automatic test_basic_presses();
        write_reg(CFG_LONG_PRESS, 16'd6);
        write_reg(CFG_DEBOUNCE, 16'd2);
        send_word(CMD_TICK, 1'b0);
        send_word(CMD_CHANGE, 1'b0);
        send_word(CMD_CHANGE, 1'b1);
        send_word(CMD_CHANGE, 1'b0);     // masked during debounce
        send_ticks(1'b1, 2);
        send_word(CMD_CHANGE, 1'b1);
        send_word(CMD_CHANGE, 1'b0);     // push
        send_ticks(1'b0, 2);
        send_word(CMD_CHANGE, 1'b1);
        send_ticks(1'b0, 2);             // released at debounce end: push
        send_ticks(1'b0, 2);
        send_word(CMD_CHANGE, 1'b0);
        send_word(CMD_CHANGE, 1'b1);
        send_ticks(1'b1, 6);             // long press
        send_word(CMD_CHANGE, 1'b0);     // release repeats the number
        send_ticks(1'b0, 2);
        settle();
    endtask

    // Zero and full-scale register values
    task automatic test_register_extremes();
        // no long-press detection
        write_reg(CFG_LONG_PRESS, 16'd0);
        write_reg(CFG_DEBOUNCE, 16'd1);
        send_word(CMD_CHANGE, 1'b1);
        send_ticks(1'b1, 4);
        send_word(CMD_CHANGE, 1'b0);
        send_word(CMD_TICK, 1'b0);
        settle();
        // no debounce: press debounce ends through the long counter
        write_reg(CFG_DEBOUNCE, 16'd0);
        write_reg(CFG_LONG_PRESS, 16'd2);
        send_word(CMD_CHANGE, 1'b1);
        send_ticks(1'b1, 2);
        settle();
        // re-press at release debounce end reloads a full long count
        write_reg(CFG_DEBOUNCE, 16'd2);
        write_reg(CFG_LONG_PRESS, 16'hFFFF);
        send_word(CMD_CHANGE, 1'b0);
        send_ticks(1'b1, 2);
        send_word(CMD_CHANGE, 1'b1);
        send_word(CMD_CHANGE, 1'b0);
        send_ticks(1'b0, 2);
        settle();
        // full debounce count cleared by a long press
        write_reg(CFG_DEBOUNCE, 16'hFFFF);
        write_reg(CFG_LONG_PRESS, 16'd3);
        send_word(CMD_CHANGE, 1'b1);
        send_ticks(1'b1, 3);
        settle();
        write_reg(CFG_DEBOUNCE, 16'd1);
        send_word(CMD_CHANGE, 1'b0);
        send_word(CMD_TICK, 1'b0);
        settle();
    endtask

    // One push per two ticks until the event number wraps past 255
    task automatic test_number_wrap();
        write_reg(CFG_LONG_PRESS, 16'd2);
        write_reg(CFG_DEBOUNCE, 16'd1);
        send_word(CMD_CHANGE, 1'b1);
        send_word(CMD_TICK, 1'b0);       // released at debounce end: push
        repeat (255) begin
            send_word(CMD_TICK, 1'b1);   // pressed again: long count reloads
            send_word(CMD_TICK, 1'b0);   // released at long count end: push
        end
        send_word(CMD_TICK, 1'b0);       // release debounce back to idle
        settle();
    endtask

    // Random press sessions over several register settings
    task automatic test_random_sessions();
        int phase;
        int start;
        for (phase = 0; phase < 3; phase++) begin
            write_reg(CFG_LONG_PRESS, ($urandom_range(0, 3) == 0) ?
                      t_ticks'($urandom_range(20, 50)) : t_ticks'($urandom_range(0, 10)));
            write_reg(CFG_DEBOUNCE, t_ticks'($urandom_range(1, 6)));
            if (phase == 2) begin
                pressure_req = 1'b1;
            end
            start = words_sent;
            while (words_sent - start < 25) begin
                if ($urandom_range(0, 6) == 0) begin
                    random_noise();
                end else begin
                    random_press();
                end
            end
            settle();
        end
    endtask

    // Back-to-back words with no debounce; the machine may lock up here
    task automatic test_zero_debounce_burst();
        int start;
        jitter_on = 1'b0;
        write_reg(CFG_DEBOUNCE, 16'd0);
        write_reg(CFG_LONG_PRESS, t_ticks'($urandom_range(1, 4)));
        start = words_sent;
        while (words_sent - start < 30) begin
            if ($urandom_range(0, 3) == 0) begin
                random_noise();
            end else begin
                random_press();
            end
        end
        settle();
    endtask

    // Result side: random stalls plus one long hold-off on request
    initial begin
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else if (pressure_req) begin
                pressure_req = 1'b0;
                hold_left    = PRESSURE_HOLD - 1;
                out_ch.ready <= 1'b0;
            end else if (jitter_on && $urandom_range(0, 5) == 0) begin
                hold_left    = $urandom_range(1, 14) - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Compare each result word against the oldest prediction
    always @(posedge clk) begin
        t_result_word exp_word;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_events.size() == 0) begin
                $display("%0t: unexpected result word kind=%0d number=%0d",
                         $realtime, out_ch.event_kind, out_ch.event_number);
                mismatches++;
            end else begin
                exp_word = expected_events.pop_front();
                if (out_ch.event_kind !== exp_word.kind) begin
                    $display("%0t: event_kind expected %0d actual %0d",
                             $realtime, exp_word.kind, out_ch.event_kind);
                    mismatches++;
                end
                if (out_ch.event_number !== exp_word.num) begin
                    $display("%0t: event_number expected %0d actual %0d",
                             $realtime, exp_word.num, out_ch.event_number);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on cycles with no word moving on any channel
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired, %0d results outstanding",
                         $realtime, expected_events.size());
                $display("Regression FAIL");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Test sequence
    initial begin
        rst_n                <= 1'b0;
        in_ch.valid          <= 1'b0;
        in_ch.command        <= CMD_CHANGE;
        in_ch.button_pressed <= 1'b0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.index         <= CFG_LONG_PRESS;
        cfg_ch.data          <= TICKS_RESET;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_basic_presses();
        test_register_extremes();
        test_number_wrap();
        test_random_sessions();
        test_zero_debounce_burst();

        repeat (8) @(posedge clk);
        if (mismatches == 0 && expected_events.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+design
design/bdlp_pkg.sv
design/bdlp_if.sv
design/bdlp_fsm.sv
design/button_debounce_long_press.sv
tb/sv/button_debounce_long_press_tb.sv
